### rtl/bil_pkg.sv
package bil_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int OPCODE_W = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_PREPEND   = 3'd1,
    OP_POP_BACK  = 3'd2,
    OP_POP_FRONT = 3'd3,
    OP_INSERT    = 3'd4,
    OP_REMOVE    = 3'd5,
    OP_FIND      = 3'd6,
    OP_READ      = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

endpackage

### rtl/bil_if.sv
// request channel
interface bil_req_if import bil_pkg::*; ();
  logic                     valid;
  logic                     ready;
  op_t                      opcode;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

// response channel
interface bil_rsp_if import bil_pkg::*; ();
  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic signed [DATA_W-1:0] data;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, output status, output data, output count, input ready);
  modport sink   (input valid, input status, input data, input count, output ready);
endinterface

### rtl/bounded_integer_list_engine.sv
// channel  direction  payload                    handshake
// req      in         opcode, value, position    valid / ready
// rsp      out        status, data, count        valid / ready
//
// one request at a time; every request gives exactly one response
// append, pop back and rejected requests finish at once; read at waits for one store read
// find reads each element; insert/prepend shift up from the last element, but a tail insert
// writes at once; remove/pop front shift down (list walk on the store's single read port)
// reset (rst, synchronous) clears the count and the control state; the store is not cleared
// a stalled response sits in the output register while the next request is taken
module bounded_integer_list_engine import bil_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  bil_req_if.sink   req,
  bil_rsp_if.source rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (POS_W > CW) ? POS_W : CW;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_UP   = 7'b0001000,
    S_PUT  = 7'b0010000,
    S_DOWN = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  // element store, one write and one registered read per cycle
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] wdata;

  // working registers
  state_t            state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [AW-1:0]     ptr, ptr_next;     // address of the word arriving on rdata
  logic [AW-1:0]     pos, pos_next;     // insert slot
  logic [DATA_W-1:0] val, val_next;
  status_t           res_status, res_status_next;
  logic [DATA_W-1:0] res_data, res_data_next;

  // output register
  logic              out_valid;
  status_t           out_status;
  logic [DATA_W-1:0] out_data;
  logic [COUNT_W-1:0] out_count;

  logic          accept;
  logic          full;
  logic          load_out;
  logic [XW-1:0] in_pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] ins_pos_x;
  logic [XW-1:0] rm_pos_x;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] cnt_a;
  logic [AW-1:0] last_a;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (cnt == CW'(DEPTH));
  assign in_pos_x  = XW'(req.position);
  assign cnt_x     = XW'(cnt);
  // prepend and pop front work as insert and remove at the head
  assign ins_pos_x = (req.opcode == OP_PREPEND) ? '0 : in_pos_x;
  assign rm_pos_x  = (req.opcode == OP_POP_FRONT) ? '0 : in_pos_x;
  assign cnt_m1    = cnt - CW'(1);
  assign cnt_a     = AW'(cnt);
  assign last_a    = AW'(cnt_m1);
  assign load_out  = (state == S_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    ptr_next        = ptr;
    pos_next        = pos;
    val_next        = val;
    res_status_next = res_status;
    res_data_next   = res_data;
    we              = 1'b0;
    waddr           = ptr;
    wdata           = rdata;
    raddr           = ptr;

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_status_next = ST_OK;
          res_data_next   = '0;
          val_next        = req.value;
          state_next      = S_DONE;
          case (req.opcode)
            OP_APPEND: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = cnt_a;
                wdata    = req.value;
                cnt_next = cnt + CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (cnt == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                cnt_next = cnt_m1;
              end
            end
            OP_PREPEND, OP_INSERT: begin
              if (ins_pos_x > cnt_x) begin
                res_status_next = ST_BADIDX;
              end else if (full) begin
                res_status_next = ST_FULL;
              end else if (ins_pos_x == cnt_x) begin
                // slot at the tail, nothing to move
                we       = 1'b1;
                waddr    = AW'(ins_pos_x);
                wdata    = req.value;
                cnt_next = cnt + CW'(1);
              end else begin
                // walk down from the last element, moving each up by one
                raddr      = last_a;
                ptr_next   = last_a;
                pos_next   = AW'(ins_pos_x);
                state_next = S_UP;
              end
            end
            OP_POP_FRONT, OP_REMOVE: begin
              if (rm_pos_x >= cnt_x) begin
                res_status_next = (req.opcode == OP_POP_FRONT) ? ST_EMPTY : ST_BADIDX;
              end else if (rm_pos_x == XW'(cnt_m1)) begin
                cnt_next = cnt_m1;
              end else begin
                // walk up from the slot after the hole, moving each down by one
                raddr      = AW'(rm_pos_x) + AW'(1);
                ptr_next   = AW'(rm_pos_x) + AW'(1);
                state_next = S_DOWN;
              end
            end
            OP_FIND: begin
              res_status_next = ST_NOTFOUND;
              if (cnt != '0) begin
                raddr      = '0;
                ptr_next   = '0;
                state_next = S_SCAN;
              end
            end
            OP_READ: begin
              if (in_pos_x >= cnt_x) begin
                res_status_next = ST_BADIDX;
              end else begin
                raddr      = AW'(in_pos_x);
                state_next = S_READ;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        res_data_next = rdata;
        state_next    = S_DONE;
      end
      S_SCAN: begin
        // later matches overwrite earlier ones
        if (rdata == val) begin
          res_status_next = ST_OK;
          res_data_next   = DATA_W'(ptr) + DATA_W'(1);
        end
        if (ptr == last_a) begin
          state_next = S_DONE;
        end else begin
          ptr_next = ptr + AW'(1);
          raddr    = ptr + AW'(1);
        end
      end
      S_UP: begin
        we    = 1'b1;
        waddr = ptr + AW'(1);
        wdata = rdata;
        if (ptr == pos) begin
          state_next = S_PUT;
        end else begin
          ptr_next = ptr - AW'(1);
          raddr    = ptr - AW'(1);
        end
      end
      S_PUT: begin
        we         = 1'b1;
        waddr      = pos;
        wdata      = val;
        cnt_next   = cnt + CW'(1);
        state_next = S_DONE;
      end
      S_DOWN: begin
        we    = 1'b1;
        waddr = ptr - AW'(1);
        wdata = rdata;
        if (ptr == last_a) begin
          cnt_next   = cnt_m1;
          state_next = S_DONE;
        end else begin
          ptr_next = ptr + AW'(1);
          raddr    = ptr + AW'(1);
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // store: read and write addresses never meet in the same cycle during a walk
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    pos        <= pos_next;
    val        <= val_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_data   <= res_data;
      out_count  <= COUNT_W'(cnt);
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.data   = out_data;
  assign rsp.count  = out_count;

  // the list never grows past its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("element count beyond capacity");

  // one request in flight: after an accept the request side closes
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while another is at work");

  // the count moves by at most one per request
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    cnt != $past(cnt) |-> (cnt == $past(cnt) + CW'(1) || cnt == $past(cnt) - CW'(1)))
    else $error("element count jumped");

  // a response only comes out of the finishing state
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_DONE))
    else $error("response raised outside the finishing state");

endmodule
